// ===== rtl/julia_set_escape_time_pixel_unit_macros.svh =====
// Assertion macros for the Julia set pixel unit checker.
// Used by jset_chk; expects aclk and aresetn in scope.
`ifndef JULIA_SET_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define JULIA_SET_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH

// Check a property outside reset.
`define JSET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define JSET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/jset_pkg.sv =====
// Shared types, constants and helpers for the Julia set escape-time pixel unit.
// No dependencies; imported by jset_div, jset_chk and the top level.
package jset_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int ITER_W     = 10;
    localparam int SCALE_W    = 10;
    localparam int IDX_W      = 8;
    localparam int RGB_W      = 16;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int FRAC_SHIFT = 17;
    localparam int MAP_SHIFT  = 8;
    localparam int Z_SHIFT    = 8;
    localparam int IDX_SHIFT  = 8;

    localparam logic [WORD_W-1:0]        ONE_Q16      = WORD_W'(65536);
    localparam logic signed [WORD_W-1:0] ESCAPE_LIMIT = WORD_W'(4 << 16);

    localparam int DIV_W  = ITER_W + IDX_SHIFT;
    localparam int DVSR_W = ITER_W;

    // (pos << FRAC_SHIFT) / size as pos * RECIP >> QUOT_SH, exact for pos < 2^COL_W
    localparam int RECIP_N    = COL_W + FRAC_SHIFT;
    localparam int RECIP_W    = RECIP_N + 1;
    localparam int MAP_PROD_W = COL_W + RECIP_W;
    localparam int X_RECIP_SH = RECIP_N + $clog2(SCREEN_WIDTH);
    localparam int Y_RECIP_SH = RECIP_N + $clog2(SCREEN_HEIGHT);
    localparam int X_QUOT_SH  = X_RECIP_SH - FRAC_SHIFT;
    localparam int Y_QUOT_SH  = Y_RECIP_SH - FRAC_SHIFT;
    localparam logic [RECIP_W-1:0] X_RECIP =
        RECIP_W'(((64'd1 << X_RECIP_SH) + 64'(SCREEN_WIDTH - 1)) / 64'(SCREEN_WIDTH));
    localparam logic [RECIP_W-1:0] Y_RECIP =
        RECIP_W'(((64'd1 << Y_RECIP_SH) + 64'(SCREEN_HEIGHT - 1)) / 64'(SCREEN_HEIGHT));

    localparam logic [COL_W-1:0]   RST_C_X   = '0;
    localparam logic [ROW_W-1:0]   RST_C_Y   = '0;
    localparam logic [ITER_W-1:0]  RST_LIMIT = ITER_W'(50);
    localparam logic [SCALE_W-1:0] RST_X_SCL = SCALE_W'(409);
    localparam logic [SCALE_W-1:0] RST_Y_SCL = SCALE_W'(307);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_X      = 3'd0,
        CFG_C_Y      = 3'd1,
        CFG_MAX_ITER = 3'd2,
        CFG_X_SCALE  = 3'd3,
        CFG_Y_SCALE  = 3'd4
    } cfg_index_t;

    function automatic logic [RGB_W-1:0] rgb565(input logic [IDX_W-1:0] idx);
        rgb565 = {idx[7:3], idx[7:2], idx[7:3]};
    endfunction

endpackage

// ===== rtl/jset_div.sv =====
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per division.
// Depends on jset_pkg for DIV_W and DVSR_W.
module jset_div import jset_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvsr_reg};
        fits      = (trial >= {1'b0, dvsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/julia_set_escape_time_pixel_unit.sv =====
// Julia set escape-time pixel unit: maps a pixel, iterates z = z*z + c, returns a color.
// Depends on jset_pkg and jset_div.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  s_       | s_valid / s_ready   | s_pixel_column, s_pixel_row
//  m_       | m_valid / m_ready   | m_color_index, m_pixel_rgb565
//  cfg_     | cfg_wr_en           | cfg_index, cfg_wr_data
//
// An item is accepted and mapped (start, then multiply, for each coordinate), then runs
// each pass in two steps (multiply, then add and compare). An item that escapes then
// gets its index from the divider and is handed to the output register; an item that
// runs all passes skips the division. After reset or a write to c_x, c_y or a scale
// the next item also maps c first. A waiting result holds the last state.
module julia_set_escape_time_pixel_unit import jset_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COL_W-1:0]      s_pixel_column,
    input  logic [ROW_W-1:0]      s_pixel_row,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IDX_W-1:0]      m_color_index,
    output logic [RGB_W-1:0]      m_pixel_rgb565,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_START,
        S_MAP_MUL,
        S_ITER_MUL,
        S_ITER_ADD,
        S_IDX_START,
        S_IDX_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MAP_CR,
        MAP_CI,
        MAP_X,
        MAP_Y
    } map_sel_t;

    state_t              state_reg, state_next;
    map_sel_t            sel_reg, sel_next;
    logic                c_stale_reg, c_stale_next;
    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;

    logic [COL_W-1:0]    c_x_reg, c_x_next;
    logic [ROW_W-1:0]    c_y_reg, c_y_next;
    logic [ITER_W-1:0]   limit_reg, limit_next;
    logic [SCALE_W-1:0]  x_scale_reg, x_scale_next;
    logic [SCALE_W-1:0]  y_scale_reg, y_scale_next;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [WORD_W-1:0]   n_reg, n_next;
    logic [WORD_W-1:0]   cr_reg, cr_next;
    logic [WORD_W-1:0]   ci_reg, ci_next;
    logic [WORD_W-1:0]   x_reg, x_next;
    logic [WORD_W-1:0]   y_reg, y_next;
    logic [WORD_W-1:0]   xx_reg, xx_next;
    logic [WORD_W-1:0]   yy_reg, yy_next;
    logic [WORD_W-1:0]   xy_reg, xy_next;

    logic [COL_W-1:0]      map_pos;
    logic [RECIP_W-1:0]    map_recip;
    logic                  map_is_y;
    logic [MAP_PROD_W-1:0] recip_prod;
    logic [WORD_W-1:0]     map_quot;
    logic [SCALE_W-1:0]    map_scale;
    logic [WORD_W-1:0]     n_shift;
    logic [WORD_W-1:0]     mapped;
    logic [WORD_W-1:0]     px;
    logic [WORD_W-1:0]     py;
    logic [WORD_W-1:0]     mag;
    logic                  escape;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DVSR_W-1:0]   div_divisor;
    logic [DIV_W-1:0]    div_quotient;
    logic                div_done;

    jset_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_comb begin
        case (sel_reg)
            MAP_CR: begin
                map_pos   = c_x_reg;
                map_recip = X_RECIP;
                map_is_y  = 1'b0;
                map_scale = x_scale_reg;
            end
            MAP_CI: begin
                map_pos   = COL_W'(c_y_reg);
                map_recip = Y_RECIP;
                map_is_y  = 1'b1;
                map_scale = y_scale_reg;
            end
            MAP_X: begin
                map_pos   = col_reg;
                map_recip = X_RECIP;
                map_is_y  = 1'b0;
                map_scale = x_scale_reg;
            end
            default: begin
                map_pos   = COL_W'(row_reg);
                map_recip = Y_RECIP;
                map_is_y  = 1'b1;
                map_scale = y_scale_reg;
            end
        endcase
    end

    assign recip_prod = MAP_PROD_W'(map_pos) * MAP_PROD_W'(map_recip);
    assign map_quot   = map_is_y ? WORD_W'(recip_prod >> Y_QUOT_SH) :
                                   WORD_W'(recip_prod >> X_QUOT_SH);

    assign n_shift = $unsigned($signed(n_reg) >>> MAP_SHIFT);
    assign mapped  = n_shift * WORD_W'(map_scale);
    assign px      = $unsigned($signed(x_reg) >>> Z_SHIFT);
    assign py      = $unsigned($signed(y_reg) >>> Z_SHIFT);
    assign mag     = xx_reg + yy_reg;
    assign escape  = ($signed(mag) > ESCAPE_LIMIT);

    assign div_start    = (state_reg == S_IDX_START);
    assign div_dividend = DIV_W'({iter_reg, {IDX_SHIFT{1'b0}}});
    assign div_divisor  = DVSR_W'(limit_reg);

    always_comb begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        c_stale_next = c_stale_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_idx_next   = m_idx_reg;
        res_idx_next = res_idx_reg;
        c_x_next     = c_x_reg;
        c_y_next     = c_y_reg;
        limit_next   = limit_reg;
        x_scale_next = x_scale_reg;
        y_scale_next = y_scale_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        iter_next    = iter_reg;
        n_next       = n_reg;
        cr_next      = cr_reg;
        ci_next      = ci_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        xx_next      = xx_reg;
        yy_next      = yy_reg;
        xy_next      = xy_reg;

        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_C_X: begin
                    c_x_next     = cfg_wr_data[COL_W-1:0];
                    c_stale_next = 1'b1;
                end
                CFG_C_Y: begin
                    c_y_next     = cfg_wr_data[ROW_W-1:0];
                    c_stale_next = 1'b1;
                end
                CFG_MAX_ITER: begin
                    limit_next = cfg_wr_data[ITER_W-1:0];
                end
                CFG_X_SCALE: begin
                    x_scale_next = cfg_wr_data[SCALE_W-1:0];
                    c_stale_next = 1'b1;
                end
                CFG_Y_SCALE: begin
                    y_scale_next = cfg_wr_data[SCALE_W-1:0];
                    c_stale_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    col_next   = s_pixel_column;
                    row_next   = s_pixel_row;
                    sel_next   = c_stale_next ? MAP_CR : MAP_X;
                    state_next = S_MAP_START;
                end
            end
            S_MAP_START: begin
                n_next     = map_quot - ONE_Q16;
                state_next = S_MAP_MUL;
            end
            S_MAP_MUL: begin
                state_next = S_MAP_START;
                case (sel_reg)
                    MAP_CR: begin
                        cr_next  = mapped;
                        sel_next = MAP_CI;
                    end
                    MAP_CI: begin
                        ci_next      = mapped;
                        c_stale_next = 1'b0;
                        sel_next     = MAP_X;
                    end
                    MAP_X: begin
                        x_next   = mapped;
                        sel_next = MAP_Y;
                    end
                    default: begin
                        y_next    = mapped;
                        iter_next = '0;
                        if (limit_reg == '0) begin
                            res_idx_next = '0;
                            state_next   = S_DONE;
                        end else begin
                            state_next = S_ITER_MUL;
                        end
                    end
                endcase
            end
            S_ITER_MUL: begin
                xx_next    = px * px;
                yy_next    = py * py;
                xy_next    = px * py;
                state_next = S_ITER_ADD;
            end
            S_ITER_ADD: begin
                if (escape) begin
                    state_next = S_IDX_START;
                end else begin
                    x_next    = xx_reg - yy_reg + cr_reg;
                    y_next    = {xy_reg[WORD_W-2:0], 1'b0} + ci_reg;
                    iter_next = iter_reg + ITER_W'(1);
                    if (iter_next == limit_reg) begin
                        res_idx_next = '0;
                        state_next   = S_DONE;
                    end else begin
                        state_next = S_ITER_MUL;
                    end
                end
            end
            S_IDX_START: begin
                state_next = S_IDX_WAIT;
            end
            S_IDX_WAIT: begin
                if (div_done) begin
                    res_idx_next = div_quotient[IDX_W-1:0];
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        sel_reg     <= sel_next;
        m_idx_reg   <= m_idx_next;
        res_idx_reg <= res_idx_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        iter_reg    <= iter_next;
        n_reg       <= n_next;
        cr_reg      <= cr_next;
        ci_reg      <= ci_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        xx_reg      <= xx_next;
        yy_reg      <= yy_next;
        xy_reg      <= xy_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            c_stale_reg <= 1'b1;
            m_valid_reg <= 1'b0;
            c_x_reg     <= RST_C_X;
            c_y_reg     <= RST_C_Y;
            limit_reg   <= RST_LIMIT;
            x_scale_reg <= RST_X_SCL;
            y_scale_reg <= RST_Y_SCL;
        end else begin
            state_reg   <= state_next;
            c_stale_reg <= c_stale_next;
            m_valid_reg <= m_valid_next;
            c_x_reg     <= c_x_next;
            c_y_reg     <= c_y_next;
            limit_reg   <= limit_next;
            x_scale_reg <= x_scale_next;
            y_scale_reg <= y_scale_next;
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_color_index  = m_idx_reg;
    assign m_pixel_rgb565 = rgb565(m_idx_reg);

endmodule

// ===== rtl/jset_chk.sv =====
// Port-level checker for the Julia set pixel unit, bound to the top level.
// Depends on jset_pkg and julia_set_escape_time_pixel_unit_macros.svh.
`include "julia_set_escape_time_pixel_unit_macros.svh"

module jset_chk import jset_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [IDX_W-1:0]      m_color_index,
    input logic [RGB_W-1:0]      m_pixel_rgb565
);

    `JSET_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "item valid after reset")

    `JSET_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_color_index) && $stable(m_pixel_rgb565), "stalled item changed")

    `JSET_ASSERT(a_rgb_packing, m_valid |-> m_pixel_rgb565 == {m_color_index[7:3], m_color_index[7:2], m_color_index[7:3]}, "color packing mismatch")

    `JSET_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready right after an accepted item")

endmodule

bind julia_set_escape_time_pixel_unit jset_chk u_jset_chk (.*);
